// ===== rtl/core/ssh_pkg.sv =====
// Shared types and constants of the scale-space gradient and Hessian stencil.
// Holds the payload structs, the line memory word and control structs, the register codes.
// Depends on nothing.
package ssh_pkg;

	localparam int MAX_WIDTH      = 2048;
	localparam int SAMPLE_BITS    = 16;
	localparam int OUT_BITS       = 20;
	localparam int COL_BITS       = $clog2(MAX_WIDTH);
	localparam int ROW_BITS       = 16;
	localparam int WIDTH_REG_BITS = 12;
	localparam int MIN_DIM        = 3;
	localparam int DIFF_BITS      = SAMPLE_BITS + 1;
	localparam int D2_BITS        = SAMPLE_BITS + 2;
	localparam int ADDR_BITS      = 3;
	localparam int DATA_BITS      = 32;

	localparam logic [WIDTH_REG_BITS-1:0] WIDTH_RESET  = WIDTH_REG_BITS'(640);
	localparam logic [ROW_BITS-1:0]       HEIGHT_RESET = ROW_BITS'(480);

	typedef logic signed [SAMPLE_BITS-1:0] ssh_sample_t;
	typedef logic signed [DIFF_BITS-1:0]   ssh_diff_t;
	typedef logic signed [D2_BITS-1:0]     ssh_d2_t;
	typedef logic signed [OUT_BITS-1:0]    ssh_res_t;
	typedef logic [COL_BITS-1:0]           ssh_col_t;
	typedef logic [ROW_BITS-1:0]           ssh_row_t;

	typedef struct packed {
		ssh_sample_t prev_sample;
		ssh_sample_t curr_sample;
		ssh_sample_t next_sample;
	} ssh_in_t;

	typedef struct packed {
		ssh_res_t grad_x;
		ssh_res_t grad_y;
		ssh_res_t grad_s;
		ssh_res_t hess_xx;
		ssh_res_t hess_yy;
		ssh_res_t hess_ss;
		ssh_res_t hess_xy;
		ssh_res_t hess_xs;
		ssh_res_t hess_ys;
		ssh_col_t centre_col;
		ssh_row_t centre_row;
	} ssh_out_t;

	// One line memory entry: the triple two rows up and the triple one row up.
	typedef struct packed {
		ssh_in_t upper;
		ssh_in_t middle;
	} ssh_lm_word_t;

	typedef struct packed {
		logic     rd_en;
		ssh_col_t rd_addr;
		logic     wr_en;
		ssh_col_t wr_addr;
	} ssh_lm_ctrl_t;

	typedef enum logic {
		REG_WIDTH  = 1'b0,
		REG_HEIGHT = 1'b1
	} ssh_reg_t;

endpackage

// ===== rtl/core/ssh_line_mem.sv =====
// Line memory of the stencil: both stored rows of triples in one word per column.
// One registered read port and one write port. Depends on ssh_pkg.
module ssh_line_mem (
	input  logic                 clk,
	input  ssh_pkg::ssh_lm_ctrl_t ctrl,
	input  ssh_pkg::ssh_lm_word_t wr_data,
	output ssh_pkg::ssh_lm_word_t rd_data
);
	import ssh_pkg::*;

	ssh_lm_word_t mem [MAX_WIDTH];
	ssh_lm_word_t rd_q;

	always_ff @(posedge clk) begin
		if (ctrl.wr_en) begin
			mem[ctrl.wr_addr] <= wr_data;
		end
	end

	// Hold the read word until the next read.
	always_ff @(posedge clk) begin
		if (ctrl.rd_en) begin
			rd_q <= mem[ctrl.rd_addr];
		end
	end

	assign rd_data = rd_q;

endmodule

// ===== rtl/core/scale_space_hessian_stencil_core.sv =====
// Top level of the scale-space gradient and Hessian stencil.
// Uses ssh_pkg and ssh_line_mem.
//
// Usage:
//   pix_*  : one transfer per pixel, a co-located triple (prev, curr, next) of three
//            adjacent scale images in raster order, Q8.8 each.
//   res_*  : one transfer per interior pixel: gradient (x, y, scale), the six Hessian
//            entries in Q10.10 and the centre pixel's column and row. Pixels of the first
//            two columns and rows of the input raster give no result.
//   APB    : image_width at address 0 (12 bits), image_height at address 4 (16 bits).
//            Write only while the block is idle. Widths outside 3..2048 are clamped,
//            heights below 3 count as 3.
// Timing:
//   A pixel moves through four registers: line memory read, 3x3x3 window, first-level
//   differences, output register.
//   Throughput is one pixel per clock while the receiver takes results; the single read
//   and single write port of the line memory, used once per pixel, set that figure.
// Reset:
//   Clears the column and row counters, the window, all valid bits and restores the
//   register defaults. The line memory keeps whatever it held; the first two rows of
//   every image rewrite it before any result reads it.
// Stall:
//   A stalled receiver holds the output register; pixels keep entering until every
//   stage holds one, then pix_ready drops. Nothing is lost or repeated.
module scale_space_hessian_stencil_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          pix_valid,
	output logic                          pix_ready,
	input  ssh_pkg::ssh_in_t              pix_data,
	output logic                          res_valid,
	input  logic                          res_ready,
	output ssh_pkg::ssh_out_t             res_data,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ssh_pkg::ADDR_BITS-1:0] paddr,
	input  logic [ssh_pkg::DATA_BITS-1:0] pwdata,
	output logic [ssh_pkg::DATA_BITS-1:0] prdata,
	output logic                          pready
);
	import ssh_pkg::*;

	// Configuration registers.
	logic [WIDTH_REG_BITS-1:0] width_q;
	ssh_row_t                  height_q;
	ssh_reg_t                  reg_sel;
	logic                      cfg_wr;

	// Raster position of the next pixel.
	ssh_col_t col_q;
	ssh_row_t row_q;

	// Stage flow control.
	logic take_s1, take_s2, take_s3, take_s4;
	logic pix_xfer;

	// Stage 1: line memory read in flight.
	logic     vld_s1, emit_s1;
	ssh_in_t  smp_s1;
	ssh_col_t addr_s1, ccol_s1;
	ssh_row_t crow_s1;

	// Stage 2: window holds the item.
	logic     vld_s2, emit_s2;
	ssh_col_t ccol_s2;
	ssh_row_t crow_s2;
	ssh_in_t  win_q [3][3];

	// Stage 3: first-level differences and sums.
	logic      vld_s3;
	ssh_diff_t dx_s3, dy_s3, ds_s3;
	ssh_diff_t sx_s3, sy_s3, ss_s3, cc2_s3;
	ssh_diff_t xya_s3, xyb_s3, xsa_s3, xsb_s3, ysa_s3, ysb_s3;
	ssh_col_t  ccol_s3;
	ssh_row_t  crow_s3;

	// Stage 4: output register.
	logic     vld_s4;
	ssh_out_t res_s4;

	// Line memory.
	ssh_lm_ctrl_t lm_ctrl;
	ssh_lm_word_t lm_wr, lm_rd;

	// Counter wrap.
	logic [WIDTH_REG_BITS-1:0] width_eff;
	ssh_row_t                  height_eff;
	logic [COL_BITS:0]         col_inc;
	logic [ROW_BITS:0]         row_inc;

	//--------------------------------------------------------------------------------------
	// Configuration port
	//--------------------------------------------------------------------------------------
	assign pready  = 1'b1;
	assign reg_sel = ssh_reg_t'(paddr[2]);
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_wr) begin
			unique case (reg_sel)
				REG_WIDTH:  width_q  <= pwdata[WIDTH_REG_BITS-1:0];
				REG_HEIGHT: height_q <= pwdata[ROW_BITS-1:0];
				default:    ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_WIDTH:  prdata = DATA_BITS'(width_q);
			REG_HEIGHT: prdata = DATA_BITS'(height_q);
			default:    prdata = '0;
		endcase
	end

	//--------------------------------------------------------------------------------------
	// Flow control: a stage takes a new item when empty or when its item moves on
	//--------------------------------------------------------------------------------------
	assign take_s4   = !vld_s4 || res_ready;
	assign take_s3   = !vld_s3 || take_s4;
	assign take_s2   = !vld_s2 || take_s3;
	assign take_s1   = !vld_s1 || take_s2;
	assign pix_ready = take_s1;
	assign pix_xfer  = pix_valid && pix_ready;

	//--------------------------------------------------------------------------------------
	// Raster counters: clamp the registers, wrap at end of row and end of image
	//--------------------------------------------------------------------------------------
	always_comb begin
		width_eff = width_q;
		if (width_q < WIDTH_REG_BITS'(MIN_DIM)) begin
			width_eff = WIDTH_REG_BITS'(MIN_DIM);
		end else if (width_q > WIDTH_REG_BITS'(MAX_WIDTH)) begin
			width_eff = WIDTH_REG_BITS'(MAX_WIDTH);
		end
		height_eff = (height_q < ROW_BITS'(MIN_DIM)) ? ROW_BITS'(MIN_DIM) : height_q;
		col_inc    = {1'b0, col_q} + 1'b1;
		row_inc    = {1'b0, row_q} + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (pix_xfer) begin
			if (WIDTH_REG_BITS'(col_inc) >= width_eff) begin
				col_q <= '0;
				if (row_inc >= {1'b0, height_eff}) begin
					row_q <= '0;
				end else begin
					row_q <= row_inc[ROW_BITS-1:0];
				end
			end else begin
				col_q <= col_inc[COL_BITS-1:0];
			end
		end
	end

	//--------------------------------------------------------------------------------------
	// Line memory: read at transfer, write back the shifted column when the item
	// leaves stage 1. Two items in flight never share a column.
	//--------------------------------------------------------------------------------------
	always_comb begin
		lm_ctrl.rd_en   = pix_xfer;
		lm_ctrl.rd_addr = col_q;
		lm_ctrl.wr_en   = vld_s1 && take_s2;
		lm_ctrl.wr_addr = addr_s1;
		lm_wr.upper     = lm_rd.middle;
		lm_wr.middle    = smp_s1;
	end

	ssh_line_mem u_line_mem (
		.clk     (clk),
		.ctrl    (lm_ctrl),
		.wr_data (lm_wr),
		.rd_data (lm_rd)
	);

	//--------------------------------------------------------------------------------------
	// Stage 1
	//--------------------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (take_s1) begin
			vld_s1 <= pix_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pix_xfer) begin
			smp_s1  <= pix_data;
			addr_s1 <= col_q;
			ccol_s1 <= col_q - 1'b1;
			crow_s1 <= row_q - 1'b1;
			emit_s1 <= (col_q >= COL_BITS'(2)) && (row_q >= ROW_BITS'(2));
		end
	end

	//--------------------------------------------------------------------------------------
	// Stage 2: shift the window by one column as the item enters
	//--------------------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					win_q[r][c] <= '0;
				end
			end
		end else if (take_s2) begin
			vld_s2 <= vld_s1;
			if (vld_s1) begin
				for (int r = 0; r < 3; r++) begin
					win_q[r][0] <= win_q[r][1];
					win_q[r][1] <= win_q[r][2];
				end
				win_q[0][2] <= lm_rd.upper;
				win_q[1][2] <= lm_rd.middle;
				win_q[2][2] <= smp_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_s2 && vld_s1) begin
			emit_s2 <= emit_s1;
			ccol_s2 <= ccol_s1;
			crow_s2 <= crow_s1;
		end
	end

	//--------------------------------------------------------------------------------------
	// Stage 3: border pixels drop here; interior ones get their pairwise terms
	//--------------------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (take_s3) begin
			vld_s3 <= vld_s2 && emit_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (take_s3) begin
			dx_s3   <= ssh_diff_t'(win_q[1][2].curr_sample) - ssh_diff_t'(win_q[1][0].curr_sample);
			dy_s3   <= ssh_diff_t'(win_q[2][1].curr_sample) - ssh_diff_t'(win_q[0][1].curr_sample);
			ds_s3   <= ssh_diff_t'(win_q[1][1].next_sample) - ssh_diff_t'(win_q[1][1].prev_sample);
			sx_s3   <= ssh_diff_t'(win_q[1][2].curr_sample) + ssh_diff_t'(win_q[1][0].curr_sample);
			sy_s3   <= ssh_diff_t'(win_q[2][1].curr_sample) + ssh_diff_t'(win_q[0][1].curr_sample);
			ss_s3   <= ssh_diff_t'(win_q[1][1].next_sample) + ssh_diff_t'(win_q[1][1].prev_sample);
			cc2_s3  <= {win_q[1][1].curr_sample, 1'b0};
			xya_s3  <= ssh_diff_t'(win_q[2][2].curr_sample) - ssh_diff_t'(win_q[0][2].curr_sample);
			xyb_s3  <= ssh_diff_t'(win_q[2][0].curr_sample) - ssh_diff_t'(win_q[0][0].curr_sample);
			xsa_s3  <= ssh_diff_t'(win_q[1][2].next_sample) - ssh_diff_t'(win_q[1][0].next_sample);
			xsb_s3  <= ssh_diff_t'(win_q[1][2].prev_sample) - ssh_diff_t'(win_q[1][0].prev_sample);
			ysa_s3  <= ssh_diff_t'(win_q[2][1].next_sample) - ssh_diff_t'(win_q[0][1].next_sample);
			ysb_s3  <= ssh_diff_t'(win_q[2][1].prev_sample) - ssh_diff_t'(win_q[0][1].prev_sample);
			ccol_s3 <= ccol_s2;
			crow_s3 <= crow_s2;
		end
	end

	//--------------------------------------------------------------------------------------
	// Stage 4: finish the sums and scale to Q10.10. With 16-bit samples every result
	// fits the 20-bit field, so no clamp is needed.
	//--------------------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (take_s4) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (take_s4) begin
			res_s4.grad_x     <= ssh_res_t'(dx_s3) <<< 2;
			res_s4.grad_y     <= ssh_res_t'(dy_s3) <<< 2;
			res_s4.grad_s     <= ssh_res_t'(ds_s3) <<< 2;
			res_s4.hess_xx    <= ssh_res_t'(ssh_d2_t'(sx_s3) - ssh_d2_t'(cc2_s3)) <<< 2;
			res_s4.hess_yy    <= ssh_res_t'(ssh_d2_t'(sy_s3) - ssh_d2_t'(cc2_s3)) <<< 2;
			res_s4.hess_ss    <= ssh_res_t'(ssh_d2_t'(ss_s3) - ssh_d2_t'(cc2_s3)) <<< 2;
			res_s4.hess_xy    <= ssh_res_t'(ssh_d2_t'(xya_s3) - ssh_d2_t'(xyb_s3));
			res_s4.hess_xs    <= ssh_res_t'(ssh_d2_t'(xsa_s3) - ssh_d2_t'(xsb_s3));
			res_s4.hess_ys    <= ssh_res_t'(ssh_d2_t'(ysa_s3) - ssh_d2_t'(ysb_s3));
			res_s4.centre_col <= ccol_s3;
			res_s4.centre_row <= crow_s3;
		end
	end

	assign res_valid = vld_s4;
	assign res_data  = res_s4;

endmodule

// ===== rtl/core/ssh_checker.sv =====
// Port-level checks for the scale-space stencil core, attached by bind.
// Depends on ssh_pkg and scale_space_hessian_stencil_core.
module ssh_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          pix_valid,
	input logic                          pix_ready,
	input logic                          res_valid,
	input logic                          res_ready,
	input ssh_pkg::ssh_out_t             res_data,
	input logic                          psel,
	input logic                          penable,
	input logic                          pwrite,
	input logic [ssh_pkg::ADDR_BITS-1:0] paddr,
	input logic [ssh_pkg::DATA_BITS-1:0] pwdata,
	input logic [ssh_pkg::DATA_BITS-1:0] prdata,
	input logic                          pready
);
	import ssh_pkg::*;

	// A stalled result holds until its transfer.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_data))
		else $error("result changed while stalled");

	// With the output register empty every stage can drain, so input is open.
	a_ready_open: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid |-> pix_ready)
		else $error("input blocked with empty output");

	// Border pixels never reach the output.
	a_interior: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res_data.centre_col != '0) && (res_data.centre_row != '0))
		else $error("border pixel produced a result");

	// A width write reads back masked to its register width.
	a_width_rb: assert property (@(posedge clk) disable iff (!arst_n)
		(psel && penable && pwrite && pready && !paddr[2]) ##1 (psel && !pwrite && !paddr[2])
		|-> prdata == (DATA_BITS'($past(pwdata[WIDTH_REG_BITS-1:0]))))
		else $error("width register readback mismatch");

endmodule

bind scale_space_hessian_stencil_core ssh_checker u_ssh_checker (.*);
